// File: design/dwf_pkg.sv
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types and constants for the DDS waveform DAC framer.
// ----------------------------------------------------------------------------
package dwf_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int PHASE_W   = 16;
    localparam int FRAME_W   = 16;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 32;

    localparam logic [FRAME_W-1:0]  FRAME_A_TAG = 16'hA000;
    localparam logic [FRAME_W-1:0]  FRAME_B_TAG = 16'h9000;
    localparam logic [SAMPLE_W-1:0] POT_FORCE   = 12'h003;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_HOST  = 2'd2;
    localparam t_kind KIND_NEXT  = 2'd3;

    // output queue: one entry per in-flight read plus two for full rate under stall
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    typedef struct packed {
        logic [3:0]          pad;
        logic [SAMPLE_W-1:0] host_amplitude;
        logic [PHASE_W-1:0]  host_increment;
        logic [SAMPLE_W-1:0] table_value;
        logic [9:0]          table_index;
        logic [1:0]          wave_select;
        logic [SAMPLE_W-1:0] pot_amp;
        logic [SAMPLE_W-1:0] pot_freq;
    } t_item;

    typedef struct packed {
        logic [FRAME_W-1:0] dac_b_frame;
        logic [FRAME_W-1:0] dac_a_frame;
    } t_frame;

endpackage

// File: design/dds_waveform_dac_framer.sv
// ----------------------------------------------------------------------------
// dds_waveform_dac_framer
// DDS phase accumulator over waveform tables in RAM, framing two DAC words.
// ----------------------------------------------------------------------------
// A tick item's RAM read and level are registered, then its frame is queued.
// Throughput: one item per cycle while the output queue has space; the single
//   waveform RAM port serves one table write or one tick lookup each cycle.
// Reset: synchronous, active low; clears control and state registers.
//   Waveform RAM contents are not cleared and must be written before use.
// ----------------------------------------------------------------------------
module dds_waveform_dac_framer #(
    parameter int TABLE_DEPTH = 1024,
    parameter int WAVE_COUNT  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // pot_freq, pot_amp, wave_select, table_index, table_value,
    // host_increment, host_amplitude, zero pad
    input  logic [dwf_pkg::S_DATA_W-1:0]   i_s_tdata,
    // kind
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // dac_a_frame, dac_b_frame
    output logic [dwf_pkg::M_DATA_W-1:0]   o_m_tdata
);

    import dwf_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int WW = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1;
    localparam int AW = WW + IW;

    t_item               w_item;
    logic                w_acc;
    logic                w_ram_en;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_addr;
    logic [SAMPLE_W-1:0] w_ram_wdata;
    logic [SAMPLE_W-1:0] w_ram_rdata;
    logic                w_s1_vld;
    logic [SAMPLE_W-1:0] w_s1_level;
    t_frame              w_frame;
    t_frame              w_out;
    logic                w_space;

    assign w_item     = t_item'(i_s_tdata);
    assign o_s_tready = w_space;
    assign w_acc      = i_s_tvalid && w_space;

    dwf_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WAVE_COUNT  (WAVE_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_kind      (t_kind'(i_s_tuser)),
        .i_item      (w_item),
        .o_ram_en    (w_ram_en),
        .o_ram_we    (w_ram_we),
        .o_ram_addr  (w_ram_addr),
        .o_ram_wdata (w_ram_wdata),
        .o_s1_vld    (w_s1_vld),
        .o_s1_level  (w_s1_level)
    );

    dwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_frame.dac_a_frame = FRAME_W'(w_ram_rdata) | FRAME_A_TAG;
    assign w_frame.dac_b_frame = FRAME_W'(w_s1_level) | FRAME_B_TAG;

    dwf_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_s1_vld),
        .i_frame    (w_frame),
        .i_inflight (w_s1_vld),
        .o_space    (w_space),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_tdata    (w_out)
    );

    assign o_m_tdata = M_DATA_W'(w_out);

endmodule

// File: design/dwf_ram.sv
// ----------------------------------------------------------------------------
// dwf_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dwf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dwf_core.sv
// ----------------------------------------------------------------------------
// dwf_core
// Phase accumulator, step/level control and waveform RAM addressing.
// ----------------------------------------------------------------------------
module dwf_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int WAVE_COUNT  = 4,
    localparam int IW  = $clog2(TABLE_DEPTH),
    localparam int WW  = (WAVE_COUNT > 1) ? $clog2(WAVE_COUNT) : 1,
    localparam int AW  = WW + IW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_acc,
    input  dwf_pkg::t_kind           i_kind,
    input  dwf_pkg::t_item           i_item,
    output logic                     o_ram_en,
    output logic                     o_ram_we,
    output logic [AW-1:0]            o_ram_addr,
    output logic [dwf_pkg::SAMPLE_W-1:0] o_ram_wdata,
    output logic                     o_s1_vld,
    output logic [dwf_pkg::SAMPLE_W-1:0] o_s1_level
);

    import dwf_pkg::*;

    localparam int TDW = $clog2(TABLE_DEPTH + 1);
    localparam int PW  = PHASE_W + TDW;

    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [PHASE_W-1:0]  r_step, n_step;
    logic [SAMPLE_W-1:0] r_level, n_level;
    logic [SAMPLE_W-1:0] r_prev_pf, n_prev_pf;
    logic [SAMPLE_W-1:0] r_prev_pa, n_prev_pa;
    logic [PHASE_W-1:0]  r_req_step, n_req_step;
    logic [SAMPLE_W-1:0] r_req_level, n_req_level;
    logic [PHASE_W-1:0]  r_prev_rs, n_prev_rs;
    logic [SAMPLE_W-1:0] r_prev_rl, n_prev_rl;
    logic [WW-1:0]       r_wave, n_wave;
    logic                r_s1_vld;
    logic [SAMPLE_W-1:0] r_s1_level;

    logic                w_tick;
    logic                w_wr;
    logic                w_ws_ok;
    logic                w_ti_ok;
    logic [PW-1:0]       w_prod;
    logic [SAMPLE_W-1:0] w_pfv;
    logic [SAMPLE_W-1:0] w_pav;

    assign w_ws_ok = 32'(i_item.wave_select) < WAVE_COUNT;
    assign w_ti_ok = 32'(i_item.table_index) < TABLE_DEPTH;
    assign w_tick  = i_acc && (i_kind == KIND_TICK);
    assign w_wr    = i_acc && (i_kind == KIND_WRITE) && w_ws_ok && w_ti_ok;
    assign w_prod  = PW'(r_phase) * PW'(TABLE_DEPTH);
    assign w_pfv   = i_item.pot_freq | POT_FORCE;
    assign w_pav   = i_item.pot_amp | POT_FORCE;

    assign o_ram_en    = w_tick || w_wr;
    assign o_ram_we    = w_wr;
    assign o_ram_addr  = w_wr ? {WW'(i_item.wave_select), IW'(i_item.table_index)}
                              : {r_wave, w_prod[PHASE_W +: IW]};
    assign o_ram_wdata = i_item.table_value;

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_level     = r_level;
        n_prev_pf   = r_prev_pf;
        n_prev_pa   = r_prev_pa;
        n_req_step  = r_req_step;
        n_req_level = r_req_level;
        n_prev_rs   = r_prev_rs;
        n_prev_rl   = r_prev_rl;
        n_wave      = r_wave;
        if (i_acc) begin
            case (i_kind)
                KIND_TICK: begin
                    if (r_prev_pf != w_pfv) begin
                        n_step    = PHASE_W'(w_pfv);
                        n_prev_pf = w_pfv;
                    end
                    if (r_prev_rs != r_req_step) begin
                        n_step    = r_req_step;
                        n_prev_rs = r_req_step;
                    end
                    n_phase = r_phase + n_step;
                    if (r_prev_pa != w_pav) begin
                        n_level   = w_pav;
                        n_prev_pa = w_pav;
                    end
                    if (r_prev_rl != r_req_level) begin
                        n_level   = r_req_level;
                        n_prev_rl = r_req_level;
                    end
                end
                KIND_HOST: begin
                    n_req_step  = i_item.host_increment;
                    n_req_level = i_item.host_amplitude;
                    if (w_ws_ok) begin
                        n_wave = WW'(i_item.wave_select);
                    end
                end
                KIND_NEXT: begin
                    if (r_wave == WW'(WAVE_COUNT - 1)) begin
                        n_wave = '0;
                    end else begin
                        n_wave = r_wave + WW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= PHASE_W'(1);
            r_level     <= SAMPLE_W'(1023);
            r_prev_pf   <= '0;
            r_prev_pa   <= '0;
            r_req_step  <= PHASE_W'(1);
            r_req_level <= SAMPLE_W'(1);
            r_prev_rs   <= PHASE_W'(1);
            r_prev_rl   <= SAMPLE_W'(1);
            r_wave      <= '0;
            r_s1_vld    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_level     <= n_level;
            r_prev_pf   <= n_prev_pf;
            r_prev_pa   <= n_prev_pa;
            r_req_step  <= n_req_step;
            r_req_level <= n_req_level;
            r_prev_rs   <= n_prev_rs;
            r_prev_rl   <= n_prev_rl;
            r_wave      <= n_wave;
            r_s1_vld    <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_level <= r_level;
        end
    end

    assign o_s1_vld   = r_s1_vld;
    assign o_s1_level = r_s1_level;

endmodule

// File: design/dwf_outq.sv
// ----------------------------------------------------------------------------
// dwf_outq
// Small output queue for DAC frame items, with space look-ahead.
// ----------------------------------------------------------------------------
module dwf_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwf_pkg::t_frame i_frame,
    input  logic            i_inflight,
    output logic            o_space,
    output logic            o_tvalid,
    input  logic            i_tready,
    output dwf_pkg::t_frame o_tdata
);

    import dwf_pkg::*;

    t_frame                r_q [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr, n_wr;
    logic [OQ_PTR_W-1:0]   r_rd, n_rd;
    logic [OQ_CNT_W-1:0]   r_cnt, n_cnt;
    logic                  w_pop;
    logic [OQ_CNT_W:0]     w_occ;

    assign w_pop    = (r_cnt != '0) && i_tready;
    assign w_occ    = {1'b0, r_cnt} + (OQ_CNT_W + 1)'(i_inflight);
    assign o_space  = w_occ < (OQ_CNT_W + 1)'(OQ_DEPTH);
    assign o_tvalid = r_cnt != '0;
    assign o_tdata  = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_wr + OQ_PTR_W'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : r_rd + OQ_PTR_W'(1);
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + OQ_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_frame;
        end
    end

endmodule

// File: test/dwf_frame_checker.sv
// ----------------------------------------------------------------------------
// dwf_frame_checker
// Watches both stream channels of the DDS waveform DAC framer, predicts the
// DAC frame pair for every accepted tick item and compares each accepted
// output item, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dwf_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [dwf_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [1:0]                   i_s_tuser,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [dwf_pkg::M_DATA_W-1:0] i_m_tdata,
    output int unsigned                  o_frames_due,
    output int unsigned                  o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import dwf_pkg::*;

    localparam int DEPTH = 1024;
    localparam int WAVES = 4;

    logic [PHASE_W-1:0]  acc_phase;
    logic [PHASE_W-1:0]  acc_step;
    logic [SAMPLE_W-1:0] out_level;
    logic [SAMPLE_W-1:0] last_pot_f;
    logic [SAMPLE_W-1:0] last_pot_a;
    logic [PHASE_W-1:0]  host_step;
    logic [SAMPLE_W-1:0] host_level;
    logic [PHASE_W-1:0]  applied_host_step;
    logic [SAMPLE_W-1:0] applied_host_level;
    int unsigned         sel_wave;
    logic [SAMPLE_W-1:0] wave_mem [WAVES][DEPTH];

    t_frame dac_frames_pending[$];
    t_frame got;
    t_frame want;

    initial o_mismatches = 0;
    initial o_frames_due = 0;

    task automatic flag_mismatch(input string what);
        $display("[%0t] dac frame mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    task automatic predict_dac_frame(input t_kind kind, input t_item it);
        int unsigned         slot;
        logic [SAMPLE_W-1:0] pf_v;
        logic [SAMPLE_W-1:0] pa_v;
        t_frame              f;
        case (kind)
            KIND_WRITE: begin
                if (it.wave_select < WAVES && it.table_index < DEPTH)
                    wave_mem[it.wave_select][it.table_index] = it.table_value;
            end
            KIND_HOST: begin
                host_step  = it.host_increment;
                host_level = it.host_amplitude;
                if (it.wave_select < WAVES)
                    sel_wave = 32'(it.wave_select);
            end
            KIND_NEXT: begin
                sel_wave = (sel_wave + 1 >= WAVES) ? 0 : sel_wave + 1;
            end
            default: begin
                slot = (32'(acc_phase) * DEPTH) >> PHASE_W;
                f.dac_a_frame = {4'h0, wave_mem[2'(sel_wave)][10'(slot)]} | FRAME_A_TAG;
                f.dac_b_frame = {4'h0, out_level} | FRAME_B_TAG;
                dac_frames_pending.push_back(f);
                pf_v = it.pot_freq | POT_FORCE;
                pa_v = it.pot_amp | POT_FORCE;
                if (last_pot_f != pf_v) begin
                    acc_step   = {4'h0, pf_v};
                    last_pot_f = pf_v;
                end
                if (applied_host_step != host_step) begin
                    acc_step          = host_step;
                    applied_host_step = host_step;
                end
                acc_phase = acc_phase + acc_step;
                if (last_pot_a != pa_v) begin
                    out_level  = pa_v;
                    last_pot_a = pa_v;
                end
                if (applied_host_level != host_level) begin
                    out_level          = host_level;
                    applied_host_level = host_level;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc_phase          = '0;
            acc_step           = 16'd1;
            out_level          = 12'd1023;
            last_pot_f         = '0;
            last_pot_a         = '0;
            host_step          = 16'd1;
            host_level         = 12'd1;
            applied_host_step  = 16'd1;
            applied_host_level = 12'd1;
            sel_wave           = 0;
            dac_frames_pending.delete();
        end else begin
            // an output item at this edge always belongs to an earlier tick
            if (i_m_tvalid && i_m_tready) begin
                got = t_frame'(i_m_tdata);
                if (dac_frames_pending.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame %h", i_m_tdata));
                end else begin
                    want = dac_frames_pending.pop_front();
                    if (got.dac_a_frame !== want.dac_a_frame)
                        flag_mismatch($sformatf("dac_a_frame %h, want %h",
                                                got.dac_a_frame, want.dac_a_frame));
                    if (got.dac_b_frame !== want.dac_b_frame)
                        flag_mismatch($sformatf("dac_b_frame %h, want %h",
                                                got.dac_b_frame, want.dac_b_frame));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_dac_frame(t_kind'(i_s_tuser), t_item'(i_s_tdata));
        end
        o_frames_due <= dac_frames_pending.size();
    end

endmodule

// File: test/tb_dds_waveform_dac_framer.sv
// ----------------------------------------------------------------------------
// tb_dds_waveform_dac_framer
// Drives table writes, host settings, waveform steps and ticks into the DDS
// waveform DAC framer with random gaps and output stalls; the frame checker
// beside the block predicts and compares every DAC frame pair.
// ----------------------------------------------------------------------------
module tb_dds_waveform_dac_framer;
    timeunit 1ns;
    timeprecision 1ps;
    import dwf_pkg::*;

    localparam int          RANDOM_ITEMS = 1700;
    localparam int unsigned STUCK_LIMIT  = 4000;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic [1:0]          i_s_tuser  = KIND_TICK;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    int unsigned frames_due;
    int unsigned mismatches;
    int unsigned stuck_cycles = 0;
    int unsigned hold_cnt     = 0;
    bit          tx_gaps      = 1'b1;
    bit          rx_gaps      = 1'b1;

    // stimulus-side tracking so that a tick never reads an unwritten entry
    bit                  table_loaded [4][1024];
    logic [PHASE_W-1:0]  gen_phase        = '0;
    logic [PHASE_W-1:0]  gen_step         = 16'd1;
    logic [SAMPLE_W-1:0] gen_last_pot_f   = '0;
    logic [PHASE_W-1:0]  gen_host_step    = 16'd1;
    logic [PHASE_W-1:0]  gen_applied_step = 16'd1;
    logic [1:0]          gen_wave         = '0;

    logic [SAMPLE_W-1:0] cur_pot_f;
    logic [SAMPLE_W-1:0] cur_pot_a;
    logic [PHASE_W-1:0]  last_hi = 16'd1;
    logic [SAMPLE_W-1:0] last_ha = 12'd1;

    always #5 i_clk = ~i_clk;

    dds_waveform_dac_framer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    dwf_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_frames_due (frames_due),
        .o_mismatches (mismatches)
    );

    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= 0;
        end else if (hold_cnt != 0) begin
            i_m_tready <= 1'b0;
            hold_cnt   <= hold_cnt - 1;
        end else begin
            i_m_tready <= 1'b1;
            hold_cnt   <= pick_gap(rx_gaps);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_dds_waveform_dac_framer failed");
            $finish;
        end
    end

    function automatic t_item noise_item();
        t_item it;
        it.pad            = '0;
        it.pot_freq       = 12'($urandom_range(0, 4095));
        it.pot_amp        = 12'($urandom_range(0, 4095));
        it.wave_select    = 2'($urandom_range(0, 3));
        it.table_index    = 10'($urandom_range(0, 1023));
        it.table_value    = 12'($urandom_range(0, 4095));
        it.host_increment = 16'($urandom_range(0, 65535));
        it.host_amplitude = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    task automatic push_item(input t_kind kind, input t_item it);
        int unsigned         gap;
        logic [SAMPLE_W-1:0] pf_v;
        case (kind)
            KIND_WRITE: table_loaded[it.wave_select][it.table_index] = 1'b1;
            KIND_HOST: begin
                gen_host_step = it.host_increment;
                gen_wave      = it.wave_select;
            end
            KIND_NEXT: gen_wave = gen_wave + 2'd1;
            default: begin
                pf_v = it.pot_freq | POT_FORCE;
                if (gen_last_pot_f != pf_v) begin
                    gen_step       = {4'h0, pf_v};
                    gen_last_pot_f = pf_v;
                end
                if (gen_applied_step != gen_host_step) begin
                    gen_step         = gen_host_step;
                    gen_applied_step = gen_host_step;
                end
                gen_phase = gen_phase + gen_step;
            end
        endcase
        gap = pick_gap(tx_gaps);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_write(input logic [1:0] ws, input logic [9:0] ti,
                              input logic [SAMPLE_W-1:0] tv);
        t_item it;
        it             = noise_item();
        it.wave_select = ws;
        it.table_index = ti;
        it.table_value = tv;
        push_item(KIND_WRITE, it);
    endtask

    task automatic send_host(input logic [1:0] ws, input logic [PHASE_W-1:0] hi,
                             input logic [SAMPLE_W-1:0] ha);
        t_item it;
        it                = noise_item();
        it.wave_select    = ws;
        it.host_increment = hi;
        it.host_amplitude = ha;
        last_hi           = hi;
        last_ha           = ha;
        push_item(KIND_HOST, it);
    endtask

    task automatic send_next();
        push_item(KIND_NEXT, noise_item());
    endtask

    task automatic send_tick(input logic [SAMPLE_W-1:0] pf, input logic [SAMPLE_W-1:0] pa);
        t_item it;
        if (!table_loaded[gen_wave][gen_phase[15:6]])
            send_write(gen_wave, gen_phase[15:6], 12'($urandom_range(0, 4095)));
        it          = noise_item();
        it.pot_freq = pf;
        it.pot_amp  = pa;
        push_item(KIND_TICK, it);
    endtask

    task automatic drain_frames();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            case ($urandom_range(0, 9))
                0: cur_pot_f = 12'($urandom_range(0, 4095));
                1: cur_pot_f = cur_pot_f ^ 12'($urandom_range(0, 3));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0: cur_pot_a = 12'($urandom_range(0, 4095));
                1: cur_pot_a = cur_pot_a ^ 12'($urandom_range(0, 3));
                default: ;
            endcase
            send_tick(cur_pot_f, cur_pot_a);
        end else if (r < 80) begin
            send_write(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                       12'($urandom_range(0, 4095)));
        end else if (r < 92) begin
            if ($urandom_range(0, 3) == 0)
                send_host(2'($urandom_range(0, 3)), last_hi, last_ha);
            else
                send_host(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                          12'($urandom_range(0, 4095)));
        end else begin
            send_next();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, unchanged pots, repeated host request, wave wrap
        send_write(2'd0, 10'd0, 12'hFFF);
        send_write(2'd3, 10'd1023, 12'h000);
        send_write(2'd1, 10'd512, 12'hAAA);
        send_write(2'd2, 10'd341, 12'h555);
        send_tick(12'h000, 12'h000);
        send_tick(12'h000, 12'h000);
        send_host(2'd0, 16'd1, 12'd1);
        send_tick(12'hFFF, 12'hFFF);
        send_host(2'd3, 16'hFFFF, 12'hFFF);
        send_tick(12'hFFF, 12'hFFF);
        send_tick(12'hFFF, 12'hFFF);
        send_host(2'd2, 16'hFFFF, 12'hFFF);
        send_tick(12'h000, 12'h000);
        send_next();
        send_tick(12'h000, 12'h000);
        send_next();
        send_next();
        send_tick(12'h001, 12'h002);
        send_next();
        send_next();
        send_host(2'd1, 16'h0000, 12'h000);
        send_tick(12'h001, 12'h002);
        send_tick(12'h7FC, 12'h800);
        drain_frames();

        cur_pot_f = 12'($urandom_range(0, 4095));
        cur_pot_a = 12'($urandom_range(0, 4095));
        for (int ph = 0; ph < 4; ph++) begin
            tx_gaps = (ph == 0 || ph == 2);
            rx_gaps = (ph == 0 || ph == 3);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
                random_item();
            drain_frames();
        end

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_dds_waveform_dac_framer passed");
        else
            $display("tb_dds_waveform_dac_framer failed");
        $finish;
    end

endmodule

// File: filelist.f
design/dwf_pkg.sv
design/dwf_ram.sv
design/dwf_core.sv
design/dwf_outq.sv
design/dds_waveform_dac_framer.sv
test/dwf_frame_checker.sv
test/tb_dds_waveform_dac_framer.sv
